[hdl/vpa_pkg.sv]
package vpa_pkg;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [1:0] STATUS_DONE     = 2'd0;
  localparam logic [1:0] STATUS_NO_FIT   = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
  localparam logic [1:0] STATUS_BAD      = 2'd3;

  localparam logic [1:0] POLICY_FIRST = 2'd0;
  localparam logic [1:0] POLICY_BEST  = 2'd1;
  localparam logic [1:0] POLICY_WORST = 2'd2;

  localparam int OWNER_W = 8;
  // table word: {begins partition, owner}
  localparam int ENTRY_W = OWNER_W + 1;

  typedef struct packed {
    logic       command;
    logic [7:0] process_id;
    logic [5:0] request_size;
  } vpa_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] start_address;
    logic [5:0] block_length;
  } vpa_rsp_t;

  typedef struct packed {
    logic clear_wr;
    logic load;
    logic scan_rd;
    logic scan_eval;
    logic scan_end;
    logic fill_wr;
    logic tail_wr;
    logic post;
  } vpa_cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic bad;
    logic found;
    logic fill_last;
    logic tail_need;
    logic out_free;
  } vpa_sts_t;

endpackage

[hdl/vpa_ram.sv]
module vpa_ram import vpa_pkg::*; #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/vpa_ctrl.sv]
module vpa_ctrl import vpa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  vpa_sts_t sts,
  output vpa_cmd_t cmd
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_CHECK  = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_DRAIN  = 4'd4;
  localparam logic [3:0] S_CLOSE  = 4'd5;
  localparam logic [3:0] S_DECIDE = 4'd6;
  localparam logic [3:0] S_FILL   = 4'd7;
  localparam logic [3:0] S_TAIL   = 4'd8;
  localparam logic [3:0] S_FINISH = 4'd9;

  logic [3:0] state, state_next;
  logic       eval_pend;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.cnt_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.load = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = sts.bad ? S_FINISH : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        cmd.scan_eval = eval_pend;
        if (sts.cnt_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        cmd.scan_eval = 1'b1;
        state_next = S_CLOSE;
      end
      S_CLOSE: begin
        cmd.scan_end = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        state_next = sts.found ? S_FILL : S_FINISH;
      end
      S_FILL: begin
        cmd.fill_wr = 1'b1;
        if (sts.fill_last) state_next = sts.tail_need ? S_TAIL : S_FINISH;
      end
      S_TAIL: begin
        cmd.tail_wr = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.post = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      eval_pend <= 1'b0;
    end else begin
      state <= state_next;
      eval_pend <= (state == S_SCAN);
    end
  end

endmodule

[hdl/vpa_datapath.sv]
module vpa_datapath import vpa_pkg::*; #(
  parameter int MEM_UNITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  vpa_cmd_t   cmd,
  output vpa_sts_t   sts,
  input  vpa_req_t   req,
  input  logic       policy_valid,
  input  logic [1:0] policy_data,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output vpa_rsp_t   rsp
);

  localparam int AW = $clog2(MEM_UNITS);
  localparam int LW = $clog2(MEM_UNITS + 1);
  localparam int CW = LW + 6;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_UNITS - 1);

  logic [1:0]         policy;
  vpa_req_t           cur;
  logic [AW-1:0]      cnt;
  logic [AW-1:0]      rd_addr_q;

  // partition being walked
  logic [AW-1:0]      ps;
  logic [LW-1:0]      pl;
  logic [OWNER_W-1:0] po;
  logic [OWNER_W-1:0] prev_po;

  // chosen partition
  logic               found;
  logic [AW-1:0]      best;
  logic [LW-1:0]      best_len;
  logic               next_free;
  logic               prev_free;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  logic               d_begins;
  logic [OWNER_W-1:0] d_owner;
  logic               opening;
  logic               closing;
  logic               is_alloc;
  logic               cand;
  logic               take;
  logic [LW-1:0]      fill_len;
  logic [AW-1:0]      fill_addr;
  logic [AW-1:0]      tail_addr;
  logic               fill_begins;

  vpa_ram #(.WIDTH(ENTRY_W), .DEPTH(MEM_UNITS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt),
    .rdata (ram_rdata)
  );

  assign d_begins = ram_rdata[ENTRY_W-1];
  assign d_owner  = ram_rdata[OWNER_W-1:0];
  assign is_alloc = (cur.command == CMD_ALLOC);
  assign opening  = d_begins || (rd_addr_q == '0);
  assign closing  = (cmd.scan_eval && opening && (rd_addr_q != '0)) || cmd.scan_end;

  assign cand = (po == '0) && (CW'(pl) >= CW'(cur.request_size));

  always_comb begin
    if (is_alloc) begin
      take = cand && (!found ||
                      (policy == POLICY_BEST && pl < best_len) ||
                      (policy == POLICY_WORST && pl > best_len));
    end else begin
      take = (po == cur.process_id) && !found;
    end
  end

  assign fill_len  = is_alloc ? LW'(cur.request_size) : best_len;
  assign fill_addr = AW'((LW + 1)'(best) + (LW + 1)'(cnt));
  assign tail_addr = AW'((LW + 1)'(best) + (LW + 1)'(fill_len));
  // an allocation always starts a partition; a release joins a free left neighbor
  assign fill_begins = (cnt == '0) && (is_alloc || !prev_free);

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = cnt;
    ram_wdata = '0;
    if (cmd.clear_wr) begin
      ram_we = 1'b1;
      ram_wdata = {cnt == '0, {OWNER_W{1'b0}}};
    end else if (cmd.fill_wr) begin
      ram_we = 1'b1;
      ram_waddr = fill_addr;
      ram_wdata = {fill_begins, is_alloc ? cur.process_id : {OWNER_W{1'b0}}};
    end else if (cmd.tail_wr) begin
      ram_we = 1'b1;
      ram_waddr = tail_addr;
      // split remainder starts a free partition; on release the right neighbor merges
      ram_wdata = {is_alloc, {OWNER_W{1'b0}}};
    end
  end

  assign sts.cnt_last  = (cnt == LAST_ADDR);
  assign sts.bad       = (cur.process_id == '0) || (is_alloc && cur.request_size == '0);
  assign sts.found     = found;
  assign sts.fill_last = ((LW + 1)'(cnt) + (LW + 1)'(1)) == (LW + 1)'(fill_len);
  assign sts.tail_need = is_alloc ? (best_len > fill_len) : next_free;
  assign sts.out_free  = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= POLICY_FIRST;
      cnt <= '0;
      rsp_valid <= 1'b0;
      found <= 1'b0;
    end else begin
      if (policy_valid) policy <= policy_data;

      if (cmd.clear_wr || cmd.scan_rd) begin
        cnt <= (cnt == LAST_ADDR) ? '0 : cnt + AW'(1);
      end else if (cmd.fill_wr) begin
        cnt <= sts.fill_last ? '0 : cnt + AW'(1);
      end else if (cmd.load) begin
        cnt <= '0;
      end

      if (cmd.load) begin
        found <= 1'b0;
      end else if (closing && take) begin
        found <= 1'b1;
      end

      if (cmd.post) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) cur <= req;
    if (cmd.scan_rd) rd_addr_q <= cnt;

    if (closing && take) begin
      best <= ps;
      best_len <= pl;
      next_free <= cmd.scan_eval && (d_owner == '0);
      prev_free <= (ps != '0) && (prev_po == '0);
    end

    if (cmd.scan_eval) begin
      if (opening) begin
        ps <= rd_addr_q;
        pl <= LW'(1);
        po <= d_owner;
        prev_po <= po;
      end else begin
        pl <= pl + LW'(1);
      end
    end
  end

  logic [AW+4:0] addr_ext;
  logic [LW+5:0] len_ext;

  assign addr_ext = (AW + 5)'(best);
  assign len_ext  = (LW + 6)'(fill_len);

  always_ff @(posedge clk) begin
    if (cmd.post) begin
      if (sts.bad) begin
        rsp <= '{status: STATUS_BAD, start_address: '0, block_length: '0};
      end else if (!found) begin
        rsp <= '{status: is_alloc ? STATUS_NO_FIT : STATUS_NOT_FOUND,
                 start_address: '0, block_length: '0};
      end else begin
        rsp <= '{status: STATUS_DONE, start_address: addr_ext[4:0],
                 block_length: len_ext[5:0]};
      end
    end
  end

endmodule

[hdl/variable_partition_allocator.sv]
// Partition allocator over a table of MEM_UNITS units.
// req channel (req_valid/req_stall/req): one word per command, allocate or release.
// rsp channel (rsp_valid/rsp_stall/rsp): exactly one word per accepted command,
// carrying status, start address and partition length.
// policy channel (policy_valid/policy_ready/policy_data): fit policy, always ready;
// write it only while the block is idle.
// After reset the owner table is swept clear, one unit per cycle, over all MEM_UNITS
// units; req_stall stays high during the sweep.
// A rejected command (zero id, or zero size on allocate) is answered without a walk.
// Any other command walks the whole table through the single read port of the
// table RAM, one unit per cycle, then, if a partition was chosen, rewrites it one unit
// per cycle: the requested size plus a split word if the partition is larger on
// allocate; its length plus a merge word if the right neighbor is free on release.
// One command is handled at a time; the next is accepted as soon as the result is
// loaded into the output register, even while that word waits on rsp_stall.
// A stalled result holds; the following command finishes its update and then waits.
module variable_partition_allocator import vpa_pkg::*; #(
  parameter int MEM_UNITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  vpa_req_t   req,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output vpa_rsp_t   rsp,
  input  logic       policy_valid,
  output logic       policy_ready,
  input  logic [1:0] policy_data
);

  vpa_cmd_t cmd;
  vpa_sts_t sts;

  assign policy_ready = 1'b1;

  vpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  vpa_datapath #(.MEM_UNITS(MEM_UNITS)) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .req          (req),
    .policy_valid (policy_valid),
    .policy_data  (policy_data),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .rsp          (rsp)
  );

endmodule

[dv/testbench.sv]
module testbench;
  import vpa_pkg::*;

  localparam int MEM_UNITS = 32;
  localparam int CYCLE_LIMIT = 800000;
  // policy code with no name in the package; behaves as first fit
  localparam logic [1:0] POLICY_SPARE = 2'd3;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_stall;
  vpa_req_t   req = '0;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  vpa_rsp_t   rsp;
  logic       policy_valid = 1'b0;
  logic       policy_ready;
  logic [1:0] policy_data = '0;

  variable_partition_allocator #(.MEM_UNITS(MEM_UNITS)) dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req          (req),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .rsp          (rsp),
    .policy_valid (policy_valid),
    .policy_ready (policy_ready),
    .policy_data  (policy_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow copy of the partition table
  logic [7:0] owner_map [MEM_UNITS];
  logic       starts_map [MEM_UNITS];
  logic [1:0] fit_mode;

  vpa_rsp_t pending_rsp [$];
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int grants = 0;
  int frees = 0;
  int cycles = 0;
  int stall_left = 0;
  bit burst_mode = 1'b0;

  function automatic int part_length(int start);
    int n;
    n = 1;
    while (start + n < MEM_UNITS && !starts_map[start + n])
      n++;
    return n;
  endfunction

  // Updates the shadow table for one command and returns the word it should produce.
  function automatic vpa_rsp_t apply_command(vpa_req_t w);
    vpa_rsp_t r;
    int i, k, len, best, best_len;
    bit found;
    r = '0;
    if (w.command == CMD_ALLOC) begin
      if (w.request_size == 0 || w.process_id == 0) begin
        r.status = STATUS_BAD;
        return r;
      end
      found = 1'b0;
      best = 0;
      best_len = 0;
      i = 0;
      while (i < MEM_UNITS) begin
        len = part_length(i);
        if (owner_map[i] == 0 && len >= w.request_size) begin
          if (!found) begin
            found = 1'b1;
            best = i;
            best_len = len;
            if (fit_mode == POLICY_FIRST || fit_mode == POLICY_SPARE)
              break;
          end else if ((fit_mode == POLICY_BEST && len < best_len) ||
                       (fit_mode == POLICY_WORST && len > best_len)) begin
            best = i;
            best_len = len;
          end
        end
        i += len;
      end
      if (!found) begin
        r.status = STATUS_NO_FIT;
        return r;
      end
      for (k = 0; k < w.request_size; k++)
        owner_map[best + k] = w.process_id;
      if (w.request_size < best_len)
        starts_map[best + w.request_size] = 1'b1;
      r.status = STATUS_DONE;
      r.start_address = best[4:0];
      r.block_length = w.request_size;
      grants++;
      return r;
    end
    if (w.process_id == 0) begin
      r.status = STATUS_BAD;
      return r;
    end
    i = 0;
    while (i < MEM_UNITS) begin
      len = part_length(i);
      if (owner_map[i] == w.process_id) begin
        for (k = 0; k < len; k++)
          owner_map[i + k] = '0;
        // merge with free neighbors on either side
        if (i + len < MEM_UNITS && owner_map[i + len] == 0)
          starts_map[i + len] = 1'b0;
        if (i > 0 && owner_map[i - 1] == 0)
          starts_map[i] = 1'b0;
        r.status = STATUS_DONE;
        r.start_address = i[4:0];
        r.block_length = len[5:0];
        frees++;
        return r;
      end
      i += len;
    end
    r.status = STATUS_NOT_FOUND;
    return r;
  endfunction

  // mostly short idle stretches, now and then a long one
  function automatic int idle_len();
    if ($urandom_range(0, 99) < 88)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_word(vpa_req_t w);
    int gap;
    gap = 0;
    if (!burst_mode && $urandom_range(0, 2) == 0)
      gap = idle_len();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= w;
    do @(posedge clk); while (req_stall);
    pending_rsp.push_back(apply_command(w));
    words_sent++;
  endtask

  task automatic send_cmd(logic cmd, logic [7:0] id, logic [5:0] size);
    vpa_req_t w;
    w.command = cmd;
    w.process_id = id;
    w.request_size = size;
    send_word(w);
  endtask

  // drop valid and hold off until every outstanding word is back
  task automatic settle();
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_fit_policy(logic [1:0] p);
    settle();
    policy_valid <= 1'b1;
    policy_data <= p;
    do @(posedge clk); while (!policy_ready);
    policy_valid <= 1'b0;
    fit_mode = p;
  endtask

  task automatic test_reject_cases();
    set_fit_policy(POLICY_FIRST);
    send_cmd(CMD_ALLOC, 8'd255, 6'd32);    // exact fit of the whole memory
    send_cmd(CMD_ALLOC, 8'd5, 6'd1);       // memory full
    send_cmd(CMD_RELEASE, 8'd255, 6'd63);
    send_cmd(CMD_RELEASE, 8'd9, 6'd0);     // id owns nothing
    send_cmd(CMD_ALLOC, 8'd5, 6'd0);
    send_cmd(CMD_ALLOC, 8'd0, 6'd4);
    send_cmd(CMD_RELEASE, 8'd0, 6'd4);
    send_cmd(CMD_ALLOC, 8'd170, 6'd33);    // larger than memory
    send_cmd(CMD_ALLOC, 8'd85, 6'd63);
    settle();
  endtask

  task automatic test_first_fit();
    set_fit_policy(POLICY_FIRST);
    send_cmd(CMD_ALLOC, 8'd1, 6'd4);
    send_cmd(CMD_ALLOC, 8'd2, 6'd8);
    send_cmd(CMD_ALLOC, 8'd3, 6'd2);
    send_cmd(CMD_ALLOC, 8'd4, 6'd6);
    send_cmd(CMD_RELEASE, 8'd1, 6'd0);
    send_cmd(CMD_RELEASE, 8'd3, 6'd0);
    send_cmd(CMD_ALLOC, 8'd6, 6'd2);
    send_cmd(CMD_ALLOC, 8'd2, 6'd1);       // id 2 now owns two partitions
    send_cmd(CMD_RELEASE, 8'd2, 6'd0);     // frees the lower one
    send_cmd(CMD_RELEASE, 8'd2, 6'd0);     // merges on both sides
    settle();
  endtask

  task automatic test_best_and_worst();
    set_fit_policy(POLICY_BEST);
    send_cmd(CMD_ALLOC, 8'd7, 6'd2);
    send_cmd(CMD_ALLOC, 8'd8, 6'd3);
    set_fit_policy(POLICY_WORST);
    send_cmd(CMD_ALLOC, 8'd9, 6'd1);
    set_fit_policy(POLICY_SPARE);
    send_cmd(CMD_ALLOC, 8'd10, 6'd1);
    send_cmd(CMD_RELEASE, 8'd4, 6'd0);
    settle();
  endtask

  task automatic test_random_traffic(logic [1:0] mode, int n_words, bit burst);
    vpa_req_t w;
    int k, r;
    set_fit_policy(mode);
    burst_mode = burst;
    for (k = 0; k < n_words; k++) begin
      r = $urandom_range(0, 99);
      w.request_size = 6'($urandom_range(0, 63));
      if ($urandom_range(0, 99) < 85)
        w.process_id = 8'($urandom_range(1, 12));
      else
        w.process_id = 8'($urandom_range(1, 255));
      if (r < 55) begin
        w.command = CMD_ALLOC;
        r = $urandom_range(0, 99);
        if (r < 70)
          w.request_size = 6'($urandom_range(1, 6));
        else if (r < 95)
          w.request_size = 6'($urandom_range(7, 32));
        else
          w.request_size = 6'($urandom_range(33, 63));
      end else if (r < 95) begin
        w.command = CMD_RELEASE;
      end else begin
        w.command = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 1))
          w.process_id = '0;
        else
          w.request_size = '0;
      end
      send_word(w);
    end
    burst_mode = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      rsp_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!burst_mode && $urandom_range(0, 3) == 0) begin
      rsp_stall <= 1'b1;
      stall_left <= idle_len() - 1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    vpa_rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        errors++;
        $display("%0t: unexpected word status=%0d addr=%0d len=%0d", $time,
                 rsp.status, rsp.start_address, rsp.block_length);
      end else begin
        want = pending_rsp.pop_front();
        words_checked++;
        if (rsp.status !== want.status || rsp.start_address !== want.start_address ||
            rsp.block_length !== want.block_length) begin
          errors++;
          $display("%0t: mismatch expected status=%0d addr=%0d len=%0d,",
                   $time, want.status, want.start_address, want.block_length,
                   " actual status=%0d addr=%0d len=%0d",
                   rsp.status, rsp.start_address, rsp.block_length);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words outstanding", cycles, pending_rsp.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    for (int u = 0; u < MEM_UNITS; u++) begin
      owner_map[u] = '0;
      starts_map[u] = (u == 0);
    end
    fit_mode = POLICY_FIRST;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_reject_cases();
    test_first_fit();
    test_best_and_worst();
    test_random_traffic(POLICY_FIRST, 250, 1'b0);
    test_random_traffic(POLICY_BEST, 250, 1'b0);
    test_random_traffic(POLICY_WORST, 250, 1'b0);
    test_random_traffic(POLICY_SPARE, 250, 1'b0);
    test_random_traffic(POLICY_BEST, 50, 1'b1);

    settle();
    repeat (100) @(posedge clk);
    $display("Sent %0d commands under all four fit policy codes: %0d allocations granted,",
             words_sent, grants);
    $display("%0d partitions released, %0d result words checked, %0d errors.",
             frees, words_checked, errors);
    if (errors == 0 && pending_rsp.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
